@@ hdl/dwwf_pkg.sv @@
// Shared types and constants for the display window write formatter.
package dwwf_pkg;

  localparam int unsigned DEF_SCREEN_WIDTH  = 240;
  localparam int unsigned DEF_SCREEN_HEIGHT = 240;

  // Screen sizes must not exceed 256 (not enforced), so a clipped coordinate fits in one byte.
  localparam int unsigned COORD_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_ENABLED = 3'd0;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  typedef struct packed {
    logic        kind;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] pixel_color;
  } in_item_t;

  typedef struct packed {
    logic       is_command;
    logic [7:0] bus_byte;
    logic       last;
    logic       window_complete;
  } out_item_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic               is_window;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] y_last;
    logic [15:0]        color;
    logic               done;
  } job_t;

endpackage

@@ hdl/dwwf_front.sv @@
// Front end: accepts items, checks and clips windows, tracks the pixel count.
module dwwf_front #(
  parameter int unsigned SCREEN_WIDTH  = dwwf_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = dwwf_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enabled_i,
  input  logic               push_i,
  input  dwwf_pkg::in_item_t in_item_i,
  input  logic               queue_full_i,
  output logic               full_o,
  output logic               job_write_o,
  output dwwf_pkg::job_t     job_o
);

  localparam logic [15:0] ScreenW = 16'(SCREEN_WIDTH);
  localparam logic [15:0] ScreenH = 16'(SCREEN_HEIGHT);
  localparam logic [15:0] XMax    = 16'(SCREEN_WIDTH - 1);
  localparam logic [15:0] YMax    = 16'(SCREEN_HEIGHT - 1);

  logic [dwwf_pkg::COUNT_W-1:0] pixels_left_q, pixels_left_d;
  logic                         accept;
  logic                         reject;
  logic [15:0]                  x_clip, y_clip;
  logic [dwwf_pkg::COORD_W:0]   span_x, span_y;
  logic [2*dwwf_pkg::COORD_W+1:0] product;
  logic [dwwf_pkg::COUNT_W-1:0] count;

  assign full_o = queue_full_i;
  assign accept = push_i && !queue_full_i;

  assign reject = !enabled_i
               || (in_item_i.x_start > in_item_i.x_end)
               || (in_item_i.y_start > in_item_i.y_end)
               || (in_item_i.x_start >= ScreenW)
               || (in_item_i.y_start >= ScreenH);

  assign x_clip = (in_item_i.x_end >= ScreenW) ? XMax : in_item_i.x_end;
  assign y_clip = (in_item_i.y_end >= ScreenH) ? YMax : in_item_i.y_end;

  assign span_x = {1'b0, x_clip[dwwf_pkg::COORD_W-1:0]}
                - {1'b0, in_item_i.x_start[dwwf_pkg::COORD_W-1:0]}
                + (dwwf_pkg::COORD_W+1)'(1);
  assign span_y = {1'b0, y_clip[dwwf_pkg::COORD_W-1:0]}
                - {1'b0, in_item_i.y_start[dwwf_pkg::COORD_W-1:0]}
                + (dwwf_pkg::COORD_W+1)'(1);
  assign product = span_x * span_y;

  // The count saturates; only a full 256 by 256 window can overflow it.
  assign count = (|product[2*dwwf_pkg::COORD_W+1:dwwf_pkg::COUNT_W])
               ? {dwwf_pkg::COUNT_W{1'b1}}
               : product[dwwf_pkg::COUNT_W-1:0];

  always_comb begin
    pixels_left_d = pixels_left_q;
    job_write_o   = 1'b0;
    job_o.is_window = (in_item_i.kind == dwwf_pkg::KIND_WINDOW);
    job_o.x_first   = in_item_i.x_start[dwwf_pkg::COORD_W-1:0];
    job_o.x_last    = x_clip[dwwf_pkg::COORD_W-1:0];
    job_o.y_first   = in_item_i.y_start[dwwf_pkg::COORD_W-1:0];
    job_o.y_last    = y_clip[dwwf_pkg::COORD_W-1:0];
    job_o.color     = in_item_i.pixel_color;
    job_o.done      = (pixels_left_q == dwwf_pkg::COUNT_W'(1));
    if (accept) begin
      if (in_item_i.kind == dwwf_pkg::KIND_PIXEL) begin
        if (enabled_i && (pixels_left_q != '0)) begin
          pixels_left_d = pixels_left_q - dwwf_pkg::COUNT_W'(1);
          job_write_o   = 1'b1;
        end
      end else if (reject) begin
        pixels_left_d = '0;
      end else begin
        pixels_left_d = count;
        job_write_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_left_q <= '0;
    end else begin
      pixels_left_q <= pixels_left_d;
    end
  end

endmodule

@@ hdl/dwwf_queue.sv @@
// Short job queue between the front end and the byte sequencer.
module dwwf_queue #(
  parameter int unsigned DEPTH = dwwf_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           write_i,
  input  dwwf_pkg::job_t job_i,
  output logic           full_o,
  input  logic           read_i,
  output logic           valid_o,
  output dwwf_pkg::job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dwwf_pkg::job_t  store_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_write, do_read;

  assign full_o   = (count_q == CntW'(DEPTH));
  assign valid_o  = (count_q != '0);
  assign job_o    = store_q[rd_ptr_q];
  assign do_write = write_i && !full_o;
  assign do_read  = read_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_read) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_write && !do_read) begin
        count_q <= count_q + CntW'(1);
      end else if (do_read && !do_write) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

@@ hdl/dwwf_back.sv @@
// Back end: walks each job byte by byte into a registered output slot.
module dwwf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  dwwf_pkg::job_t      job_i,
  output logic                job_read_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dwwf_pkg::out_item_t out_item_o
);

  localparam logic [3:0] StepCmdCol   = 4'd0;
  localparam logic [3:0] StepXFirstHi = 4'd1;
  localparam logic [3:0] StepXFirstLo = 4'd2;
  localparam logic [3:0] StepXLastHi  = 4'd3;
  localparam logic [3:0] StepXLastLo  = 4'd4;
  localparam logic [3:0] StepCmdRow   = 4'd5;
  localparam logic [3:0] StepYFirstHi = 4'd6;
  localparam logic [3:0] StepYFirstLo = 4'd7;
  localparam logic [3:0] StepYLastHi  = 4'd8;
  localparam logic [3:0] StepYLastLo  = 4'd9;
  localparam logic [3:0] StepCmdWrite = 4'd10;
  localparam logic [3:0] StepPixelHi  = 4'd0;
  localparam logic [3:0] StepPixelLo  = 4'd1;

  logic [3:0]          step_q;
  logic                out_valid_q;
  dwwf_pkg::out_item_t out_q, out_d;
  logic                load, last_step;
  logic [15:0]         xf, xl, yf, yl;

  assign xf = 16'(job_i.x_first);
  assign xl = 16'(job_i.x_last);
  assign yf = 16'(job_i.y_first);
  assign yl = 16'(job_i.y_last);

  assign last_step  = job_i.is_window ? (step_q == StepCmdWrite) : (step_q == StepPixelLo);
  assign load       = job_valid_i && (!out_valid_q || pop_i);
  assign job_read_o = load && last_step;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    out_d.is_command      = 1'b0;
    out_d.bus_byte        = '0;
    out_d.last            = last_step;
    out_d.window_complete = 1'b0;
    if (job_i.is_window) begin
      unique case (step_q)
        StepCmdCol: begin
          out_d.is_command = 1'b1;
          out_d.bus_byte   = dwwf_pkg::CMD_COLUMN_SET;
        end
        StepXFirstHi: out_d.bus_byte = xf[15:8];
        StepXFirstLo: out_d.bus_byte = xf[7:0];
        StepXLastHi:  out_d.bus_byte = xl[15:8];
        StepXLastLo:  out_d.bus_byte = xl[7:0];
        StepCmdRow: begin
          out_d.is_command = 1'b1;
          out_d.bus_byte   = dwwf_pkg::CMD_ROW_SET;
        end
        StepYFirstHi: out_d.bus_byte = yf[15:8];
        StepYFirstLo: out_d.bus_byte = yf[7:0];
        StepYLastHi:  out_d.bus_byte = yl[15:8];
        StepYLastLo:  out_d.bus_byte = yl[7:0];
        StepCmdWrite: begin
          out_d.is_command = 1'b1;
          out_d.bus_byte   = dwwf_pkg::CMD_MEMORY_WRITE;
        end
        default: out_d.bus_byte = '0;
      endcase
    end else begin
      if (step_q == StepPixelHi) begin
        out_d.bus_byte = job_i.color[15:8];
      end else begin
        out_d.bus_byte        = job_i.color[7:0];
        out_d.window_complete = job_i.done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= last_step ? '0 : step_q + 4'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/display_window_write_formatter.sv @@
// Top level of the display window write formatter with its register port.
//
// Input items enter through push/full, results leave through empty/pop.
// A window item produces eleven byte writes (column set, four column
// bytes, row set, four row bytes, memory write); a pixel item produces two
// data bytes while the open window still expects pixels. Rejected windows
// and dropped pixels produce no results.
// The first result of an item passes through the job queue and the
// registered output slot. The output sequencer emits one byte per cycle
// while pop keeps up: two bytes per pixel item, eleven per window item.
// Items are accepted every cycle while the four-entry job queue has room.
// When pop stays low the output byte holds, the sequencer pauses, the job
// queue fills and full rises; no item is lost.
// Reset empties the queue and output, clears the pixel count and clears
// display_enabled, so every item is dropped until the enable register at
// address 0 is written with 1.
module display_window_write_formatter #(
  parameter int unsigned SCREEN_WIDTH  = dwwf_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = dwwf_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  dwwf_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output dwwf_pkg::out_item_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwwf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dwwf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dwwf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic           enabled_q;
  logic           queue_full, job_write, job_valid, job_read;
  dwwf_pkg::job_t job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr == dwwf_pkg::REG_DISPLAY_ENABLED)
                ? dwwf_pkg::CFG_DATA_W'(enabled_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (psel && penable && pwrite
                 && (paddr == dwwf_pkg::REG_DISPLAY_ENABLED)) begin
      enabled_q <= pwdata[0];
    end
  end

  dwwf_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enabled_i   (enabled_q),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .queue_full_i(queue_full),
    .full_o      (full),
    .job_write_o (job_write),
    .job_o       (job_in)
  );

  dwwf_queue #(
    .DEPTH(dwwf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .write_i(job_write),
    .job_i  (job_in),
    .full_o (queue_full),
    .read_i (job_read),
    .valid_o(job_valid),
    .job_o  (job_out)
  );

  dwwf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_read_o (job_read),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule
